@@ hdl/tls_flow_window_feature_extractor_macros.svh @@
// Assertion macros shared by the block's modules.
`ifndef TLS_FLOW_WINDOW_FEATURE_EXTRACTOR_MACROS_SVH
`define TLS_FLOW_WINDOW_FEATURE_EXTRACTOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TFW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define TFW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ hdl/tfwfe_pkg.sv @@
// Package with the block's types, constants and feature codes.
package tfwfe_pkg;

  localparam int unsigned FlowEntriesDefault = 1024;
  localparam logic [15:0] TlsPort            = 16'd443;
  localparam logic [7:0]  TlsAppData         = 8'd23;
  localparam logic [15:0] TlsHdrLen          = 16'd5;
  localparam int unsigned FeatureCount       = 16;
  localparam logic [15:0] DefaultWindow      = 16'd16;
  localparam int unsigned SlotW              = 10;
  localparam int unsigned FeatW              = 48;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [1:0] DirNone   = 2'd0;
  localparam logic [1:0] DirClient = 2'd1;
  localparam logic [1:0] DirServer = 2'd2;

  // One flow entry as stored in memory.
  typedef struct packed {
    logic [15:0] cpkts;
    logic [15:0] spkts;
    logic [31:0] cbytes;
    logic [31:0] sbytes;
    logic [15:0] cmin;
    logic [15:0] cmax;
    logic [15:0] smin;
    logic [15:0] smax;
    logic [1:0]  pdir;
    logic [15:0] nsw;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Classified packet handed from front to back.
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             newf;
    logic             server;
    logic [15:0]      rlen;
  } pkt_t;

  localparam entry_t EntryClear = '{cpkts: '0, spkts: '0, cbytes: '0, sbytes: '0,
                                    cmin: '1, cmax: '0, smin: '1, smax: '0,
                                    pdir: DirNone, nsw: '0};

endpackage

@@ hdl/tls_flow_window_feature_extractor.sv @@
// Top level of the TLS flow window feature extractor.
// Usage:
//   Drive a parsed packet on the input ports with start high; the transaction is
//   taken at a clock edge where busy is low. Non-TLS or malformed packets are dropped.
//   Kept records pass through a two-entry queue to a back end that does a
//   read-modify-write of the flow entry (registered memory read, then write-back)
//   and takes the next record only once it is done with the last; busy rises only
//   while the queue holds two records.
//   When a flow's packet count reaches the window, 16 features are emitted on
//   valid_o in index order; integer features are emitted directly and the five
//   ratio and mean features pass through the 64-step bit-serial divider; the
//   stored entry is cleared at write-back and the features use a captured copy.
//   Results are shown for one cycle; the receiver cannot stall.
//   After reset, a clearing pass writes all FLOW_ENTRIES entries of the flow memory;
//   kept records wait in the queue meanwhile. The window register resets to 16
//   and is written through flow_window_we_i; write it only when idle.
module tls_flow_window_feature_extractor
  import tfwfe_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = FlowEntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             flow_window_we_i,
  input  logic [15:0]      flow_window_i,
  input  logic [9:0]       flow_slot_i,
  input  logic             new_flow_i,
  input  logic             parse_ok_i,
  input  logic [15:0]      source_port_i,
  input  logic [15:0]      dest_port_i,
  input  logic [15:0]      payload_length_i,
  input  logic [7:0]       record_type_i,
  input  logic [15:0]      record_length_i,
  output logic             valid_o,
  output logic [9:0]       out_flow_slot_o,
  output logic [3:0]       feature_index_o,
  output logic [47:0]      feature_value_o,
  output logic             last_feature_o
);
  logic [15:0] win_q;
  logic        full, empty, pop;
  pkt_t        head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= DefaultWindow;
    else if (flow_window_we_i) win_q <= flow_window_i;
  end

  // Hold intake while the queue is full.
  assign busy = full;

  tfwfe_front #(.FlowEntries(FLOW_ENTRIES)) u_front (
    .clk_i, .rst_ni, .start, .busy,
    .flow_slot_i, .new_flow_i, .parse_ok_i, .source_port_i, .dest_port_i,
    .payload_length_i, .record_type_i, .record_length_i,
    .full_o (full), .empty_o (empty), .pop_i (pop), .head_o (head)
  );

  tfwfe_back #(.FlowEntries(FLOW_ENTRIES)) u_back (
    .clk_i, .rst_ni, .window_i (win_q), .empty_i (empty), .head_i (head),
    .pop_o (pop), .valid_o,
    .out_flow_slot_o, .feature_index_o, .feature_value_o, .last_feature_o
  );
endmodule

@@ hdl/tfwfe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module tfwfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/tfwfe_front.sv @@
// Front end: filters TLS application-data records and queues them for the back end.
module tfwfe_front
  import tfwfe_pkg::*;
#(
  parameter int unsigned FlowEntries = FlowEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [9:0]  flow_slot_i,
  input  logic        new_flow_i,
  input  logic        parse_ok_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  record_type_i,
  input  logic [15:0] record_length_i,
  output logic        full_o,
  output logic        empty_o,
  input  logic        pop_i,
  output pkt_t        head_o
);
  `include "tls_flow_window_feature_extractor_macros.svh"

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic  keep;
  logic  push;
  pkt_t  pkt;
  pkt_t  q_mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  always_comb begin
    keep = parse_ok_i
        && (source_port_i == TlsPort || dest_port_i == TlsPort)
        && (payload_length_i >= TlsHdrLen)
        && (record_type_i == TlsAppData)
        && (record_length_i <= payload_length_i - TlsHdrLen)
        && ({7'd0, flow_slot_i} < 17'(FlowEntries));
    pkt.slot   = flow_slot_i;
    pkt.newf   = new_flow_i;
    pkt.server = (source_port_i == TlsPort);
    pkt.rlen   = record_length_i;
  end

  assign push    = start && !busy && keep;
  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= pkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop_i);
    end
  end

  `TFW_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !full_o, "push into full queue")
  `TFW_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `TFW_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= (PtrW+1)'(QueueDepth),
                     "queue count out of range")
endmodule

@@ hdl/tfwfe_div.sv @@
// Radix-2 restoring divider: 64-bit numerator by 32-bit denominator, 48-bit quotient.
module tfwfe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [47:0] quot_o
);
  logic [63:0] n_q;
  logic [32:0] r_q;
  logic [31:0] d_q;
  logic [6:0]  cnt_q;
  logic        run_q;
  logic [32:0] r_sh;
  logic [33:0] diff;

  always_comb begin
    r_sh = {r_q[31:0], n_q[63]};
    diff = {1'b0, r_sh} - {2'b0, d_q};
  end

  assign quot_o = n_q[47:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (run_q) begin
      if (!diff[33]) begin
        r_q <= diff[32:0];
        n_q <= {n_q[62:0], 1'b1};
      end else begin
        r_q <= r_sh;
        n_q <= {n_q[62:0], 1'b0};
      end
    end
  end
endmodule

@@ hdl/tfwfe_back.sv @@
// Back end: post-reset memory clear, read-modify-write of the flow entry, window check and feature emission.
module tfwfe_back
  import tfwfe_pkg::*;
#(
  parameter int unsigned FlowEntries = FlowEntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      window_i,
  input  logic             empty_i,
  input  pkt_t             head_i,
  output logic             pop_o,
  output logic             valid_o,
  output logic [SlotW-1:0] out_flow_slot_o,
  output logic [3:0]       feature_index_o,
  output logic [FeatW-1:0] feature_value_o,
  output logic             last_feature_o
);
  `include "tls_flow_window_feature_extractor_macros.svh"

  localparam int unsigned AddrW = (FlowEntries > 1) ? $clog2(FlowEntries) : 1;

  typedef enum logic [2:0] {StClear, StIdle, StRead, StUpd, StFeat, StDiv, StWait} state_e;

  state_e          state_q;
  logic [AddrW-1:0] clr_q;
  pkt_t            pkt_q;
  entry_t          ent_q;
  logic [3:0]      fidx_q;
  logic [15:0]     win;
  logic [16:0]     total;
  logic            ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t          ram_wdata, ram_rdata, cur, upd;
  logic [32:0]     gsum;
  logic [15:0]     gmin, gmax;
  logic            use_div;
  logic [31:0]     dnum, dden;
  logic [47:0]     fint;
  logic            dgo, ddone;
  logic [47:0]     dquot;

  // Read the popped transaction's entry while in StRead.
  tfwfe_ram #(.Width(EntryW), .Depth(FlowEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pkt_q.slot[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  tfwfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (dgo),
    .num_i  ({16'd0, dnum, 16'd0}),
    .den_i  (dden),
    .done_o (ddone),
    .quot_o (dquot)
  );

  assign win = (window_i == '0) ? DefaultWindow : window_i;

  // Update the entry with the queued record.
  always_comb begin
    cur = pkt_q.newf ? EntryClear : ram_rdata;
    upd = cur;
    if (!pkt_q.server) begin
      if (cur.cpkts == '0) begin
        upd.cmin = pkt_q.rlen;
        upd.cmax = pkt_q.rlen;
      end else begin
        if (pkt_q.rlen < cur.cmin) upd.cmin = pkt_q.rlen;
        if (pkt_q.rlen > cur.cmax) upd.cmax = pkt_q.rlen;
      end
      upd.cbytes = cur.cbytes + {16'd0, pkt_q.rlen};
      upd.cpkts  = cur.cpkts + 16'd1;
      upd.pdir   = DirClient;
    end else begin
      if (cur.spkts == '0) begin
        upd.smin = pkt_q.rlen;
        upd.smax = pkt_q.rlen;
      end else begin
        if (pkt_q.rlen < cur.smin) upd.smin = pkt_q.rlen;
        if (pkt_q.rlen > cur.smax) upd.smax = pkt_q.rlen;
      end
      upd.sbytes = cur.sbytes + {16'd0, pkt_q.rlen};
      upd.spkts  = cur.spkts + 16'd1;
      upd.pdir   = DirServer;
    end
    if (cur.pdir != DirNone && cur.pdir != upd.pdir) upd.nsw = cur.nsw + 16'd1;
  end

  // Feature selection from the captured entry.
  always_comb begin
    total = {1'b0, ent_q.cpkts} + {1'b0, ent_q.spkts};
    gsum  = '0;
    gmin  = '0;
    gmax  = '0;
    if (ent_q.cpkts != '0) begin
      gmin = ent_q.cmin;
      gmax = ent_q.cmax;
      gsum = {1'b0, ent_q.cbytes};
    end
    if (ent_q.spkts != '0) begin
      if (ent_q.cpkts == '0 || ent_q.smin < gmin) gmin = ent_q.smin;
      if (ent_q.smax > gmax) gmax = ent_q.smax;
      gsum = gsum + {1'b0, ent_q.sbytes};
    end
    use_div = 1'b0;
    dnum    = '0;
    dden    = '0;
    fint    = '0;
    unique case (fidx_q)
      4'd0:  fint = (ent_q.cpkts != '0) ? {16'd0, ent_q.cmax, 16'd0} : '0;
      4'd1:  fint = {16'd0, ent_q.cpkts, 16'd0};
      4'd2:  begin use_div = 1'b1; dnum = ent_q.cbytes;
                   dden = ent_q.cbytes + ent_q.sbytes; end
      4'd3:  fint = {16'd0, ent_q.spkts, 16'd0};
      4'd4:  begin use_div = 1'b1; dnum = {16'd0, ent_q.cpkts}; dden = {15'd0, total}; end
      4'd5:  fint = {ent_q.cbytes, 16'd0};
      4'd6:  fint = (ent_q.spkts != '0) ? {16'd0, ent_q.smax, 16'd0} : '0;
      4'd7:  fint = {16'd0, gmin, 16'd0};
      4'd8:  begin use_div = 1'b1; dnum = gsum[31:0]; dden = {15'd0, total}; end
      4'd9:  begin use_div = 1'b1; dnum = ent_q.sbytes; dden = {16'd0, ent_q.spkts}; end
      4'd10: fint = {16'd0, ent_q.nsw, 16'd0};
      4'd11: fint = {ent_q.sbytes, 16'd0};
      4'd12: fint = {16'd0, gmax, 16'd0};
      4'd13: fint = (ent_q.cpkts != '0) ? {16'd0, ent_q.cmin, 16'd0} : '0;
      4'd14: fint = (ent_q.spkts != '0) ? {16'd0, ent_q.smin, 16'd0} : '0;
      4'd15: begin use_div = 1'b1; dnum = ent_q.cbytes; dden = {16'd0, ent_q.cpkts}; end
      default: fint = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pkt_q.slot[AddrW-1:0];
    ram_wdata = upd;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = EntryClear;
    end else if (state_q == StUpd) begin
      ram_we = 1'b1;
      if ({1'b0, upd.cpkts} + {1'b0, upd.spkts} >= {1'b0, win}) ram_wdata = EntryClear;
    end
  end

  assign pop_o  = (state_q == StIdle) && !empty_i;
  assign dgo    = (state_q == StFeat) && use_div && (dden != '0);
  assign out_flow_slot_o = pkt_q.slot;

  always_ff @(posedge clk_i) begin
    if (pop_o) pkt_q <= head_i;
    if (state_q == StUpd) ent_q <= upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StClear;
      clr_q           <= '0;
      fidx_q          <= '0;
      valid_o         <= 1'b0;
      feature_index_o <= '0;
      feature_value_o <= '0;
      last_feature_o  <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(FlowEntries - 1)) state_q <= StIdle;
        end
        StIdle: if (!empty_i) state_q <= StRead;
        StRead: state_q <= StUpd;
        StUpd: begin
          fidx_q <= '0;
          if ({1'b0, upd.cpkts} + {1'b0, upd.spkts} >= {1'b0, win}) state_q <= StFeat;
          else state_q <= StIdle;
        end
        StFeat: begin
          if (dgo) begin
            state_q <= StDiv;
          end else begin
            valid_o         <= 1'b1;
            feature_index_o <= fidx_q;
            feature_value_o <= fint;
            last_feature_o  <= (fidx_q == 4'd15);
            fidx_q          <= fidx_q + 4'd1;
            state_q         <= (fidx_q == 4'd15) ? StIdle : StFeat;
          end
        end
        StDiv: state_q <= StWait;
        StWait: begin
          if (ddone) begin
            valid_o         <= 1'b1;
            feature_index_o <= fidx_q;
            feature_value_o <= dquot;
            last_feature_o  <= (fidx_q == 4'd15);
            fidx_q          <= fidx_q + 4'd1;
            state_q         <= (fidx_q == 4'd15) ? StIdle : StFeat;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `TFW_ASSERT_IMPL(a_last_idx, clk_i, rst_ni, valid_o && last_feature_o,
                   feature_index_o == 4'd15, "last flag off index 15")
  `TFW_ASSERT_IMPL(a_emit_state, clk_i, rst_ni, valid_o,
                   state_q == StFeat || state_q == StIdle, "emit from unexpected state")
  `TFW_ASSERT_IMPL(a_div_wait, clk_i, rst_ni, ddone, state_q == StWait,
                   "divider done outside wait")
endmodule
